@@ rtl/pirx_pkg.sv @@
// Package: shared constants, field layout and command types for the XOR block scan.
`default_nettype none

package pirx_pkg;

  // Store geometry
  localparam int MaxBlocks     = 1024;
  localparam int WordsPerBlock = 8;
  localparam int StoreWords    = MaxBlocks * WordsPerBlock;
  localparam int BlkIdxW       = $clog2(MaxBlocks);
  localparam int WordIdxW      = $clog2(WordsPerBlock);
  localparam int AddrW         = BlkIdxW + WordIdxW;

  // Field widths fixed by the interface
  localparam int OpW     = 2;
  localparam int WordW   = 64;
  localparam int SelW    = 8;
  localparam int BcntW   = 11;
  localparam int IdxOutW = 3;

  // Selection byte position, saturating one past the last block group
  localparam int PosLimit = (MaxBlocks + SelW - 1) / SelW;
  localparam int PosW     = $clog2(PosLimit + 1);
  localparam int SelBitW  = $clog2(SelW);
  localparam int BlkSelW  = PosW + SelBitW;
  localparam int CmpW     = (BlkSelW > BcntW) ? BlkSelW : BcntW;
  localparam int LimitW   = BcntW + WordIdxW;

  // Input word layout, lowest bit first
  localparam int InOpLo    = 0;
  localparam int InAddrLo  = InOpLo + OpW;
  localparam int InWdataLo = InAddrLo + AddrW;
  localparam int InSelLo   = InWdataLo + WordW;
  localparam int InFieldW  = InSelLo + SelW;
  localparam int InTdataW  = ((InFieldW + 7) / 8) * 8;

  // Output word layout, lowest bit first
  localparam int OutIdxLo  = WordW;
  localparam int OutFieldW = WordW + IdxOutW;
  localparam int OutTdataW = ((OutFieldW + 7) / 8) * 8;

  // Command queue
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // One classified command as it travels from front to back
  typedef struct packed {
    opcode_e            kind;
    logic [AddrW-1:0]   addr;
    logic [WordW-1:0]   wdata;
    logic [SelW-1:0]    sel;
    logic               last;
    logic               in_range;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/pir_selected_block_xor.sv @@
// Top level: XOR block scan over a word store, with block count register.
`default_nettype none

// A store of 1024 blocks of eight 64-bit words is written and read a word at a
// time, and queried with streamed selection bytes (bit 7 picks the lowest of
// the eight blocks a byte covers). Input words are decoded and range-checked on
// entry and wait in a two-entry queue, so the input side keeps taking words
// while the back end works, until the queue is full. The back end owns the
// single-port store and reads at most one store word per cycle. A write is
// done on leaving the queue, a read via the registered store output. Each
// selection byte is taken from the queue, swept over eight blocks times eight
// words and its last read drained, whatever bits it carries. The byte marked
// tlast then sends the eight accumulated words out, one per cycle while the
// sink is ready, and clears the accumulator. Store contents are undefined
// after reset; load every block in use before querying it. block_count may
// be written only while the block is idle; values above 1024 act as 1024.
module pir_selected_block_xor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pirx_pkg::BcntW-1:0]     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // opcode, word_address, write_data, select_byte
  input  wire logic [pirx_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // last_byte
  input  wire logic                           s_axis_tlast_i,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // result_word, word_index
  output      logic [pirx_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // out_of_range
  output      logic                           m_axis_tuser_o,
  // last_word
  output      logic                           m_axis_tlast_o
);
  import pirx_pkg::*;

  logic [BcntW-1:0] bcnt_q;
  logic [BcntW-1:0] nblocks;
  logic             push, full, pop, head_vld;
  cmd_t             push_cmd, head;

  // Block count register, clamped to the store size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= BcntW'(MaxBlocks);
    end else if (cfg_we_i) begin
      bcnt_q <= cfg_wdata_i;
    end
  end

  assign nblocks = (bcnt_q > BcntW'(MaxBlocks)) ? BcntW'(MaxBlocks) : bcnt_q;

  pirx_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .nblocks_i       (nblocks),
    .full_i          (full),
    .push_o          (push),
    .push_cmd_o      (push_cmd)
  );

  pirx_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .head_vld_o (head_vld)
  );

  pirx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .nblocks_i       (nblocks),
    .head_i          (head),
    .head_vld_i      (head_vld),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ rtl/pirx_front.sv @@
// Front end: takes input words, decodes the opcode and checks the address range.
`default_nettype none

module pirx_front (
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  // opcode, word_address, write_data, select_byte
  input  wire logic [pirx_pkg::InTdataW-1:0] s_axis_tdata_i,
  // last_byte
  input  wire logic                          s_axis_tlast_i,
  input  wire logic [pirx_pkg::BcntW-1:0]    nblocks_i,
  input  wire logic                          full_i,
  output      logic                          push_o,
  output      pirx_pkg::cmd_t                push_cmd_o
);
  import pirx_pkg::*;

  logic [OpW-1:0]    opcode;
  logic [AddrW-1:0]  addr;
  logic [LimitW-1:0] limit;
  logic              known;
  opcode_e           kind;

  assign opcode = s_axis_tdata_i[InOpLo +: OpW];
  assign addr   = s_axis_tdata_i[InAddrLo +: AddrW];
  assign limit  = {nblocks_i, {WordIdxW{1'b0}}};

  // Classify; the unused opcode is taken and dropped
  always_comb begin
    known = 1'b1;
    case (opcode)
      OP_WRITE: kind = OP_WRITE;
      OP_QUERY: kind = OP_QUERY;
      OP_READ:  kind = OP_READ;
      default: begin
        kind  = OP_WRITE;
        known = 1'b0;
      end
    endcase
  end

  // Command fields in declaration order: kind, addr, wdata, sel, last, in_range
  assign push_cmd_o = {kind,
                       addr,
                       s_axis_tdata_i[InWdataLo +: WordW],
                       s_axis_tdata_i[InSelLo +: SelW],
                       s_axis_tlast_i,
                       (LimitW'(addr) < limit)};

  assign s_axis_tready_o = ~full_i;
  assign push_o          = s_axis_tvalid_i & ~full_i & known;

endmodule

`default_nettype wire

@@ rtl/pirx_queue.sv @@
// Short command queue between front end and back end.
`default_nettype none

module pirx_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pirx_pkg::cmd_t push_cmd_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      pirx_pkg::cmd_t head_o,
  output      logic           head_vld_o
);
  import pirx_pkg::*;

  cmd_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QueueDepth));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = entry_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pirx_back.sv @@
// Back end: block store, selection scan, XOR accumulator and output register.
`default_nettype none

module pirx_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [pirx_pkg::BcntW-1:0]     nblocks_i,
  input  wire pirx_pkg::cmd_t                 head_i,
  input  wire logic                           head_vld_i,
  output      logic                           pop_o,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // result_word, word_index
  output      logic [pirx_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // out_of_range
  output      logic                           m_axis_tuser_o,
  // last_word
  output      logic                           m_axis_tlast_o
);
  import pirx_pkg::*;

  localparam int ScanW = SelBitW + WordIdxW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RD_OUT = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Block store
  logic [WordW-1:0] mem [StoreWords];
  logic [WordW-1:0] mem_rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;

  // Scan and accumulate
  logic [WordW-1:0]    acc_q [WordsPerBlock];
  logic [ScanW-1:0]    scan_q, scan_d;
  logic [SelW-1:0]     sel_q, sel_d;
  logic                last_q, last_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                rd_vld_q, rd_vld_d;
  logic [WordIdxW-1:0] rd_w_q, rd_w_d;
  logic [SelBitW-1:0]  bit_i;
  logic [WordIdxW-1:0] scan_w;
  logic [BlkSelW-1:0]  blk;
  logic                hit;

  // Read-back and emit
  logic [WordIdxW-1:0] rd_idx_q, rd_idx_d;
  logic                rd_rng_q, rd_rng_d;
  logic [WordIdxW-1:0] emit_q, emit_d;
  logic                acc_clr;

  // Output register
  logic                out_vld_q;
  logic [WordW-1:0]    out_word_q, out_word_d;
  logic [IdxOutW-1:0]  out_idx_q, out_idx_d;
  logic                out_last_q, out_last_d;
  logic                out_oor_q, out_oor_d;
  logic                can_load, out_load;

  assign can_load = ~out_vld_q | m_axis_tready_i;

  // Current block of the scan: bit 7 of the byte is the lowest block
  assign bit_i  = scan_q[ScanW-1:WordIdxW];
  assign scan_w = scan_q[WordIdxW-1:0];
  assign blk    = {pos_q, bit_i};
  assign hit    = sel_q[~bit_i] & (CmpW'(blk) < CmpW'(nblocks_i));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = head_i.addr;
    scan_d     = scan_q;
    sel_d      = sel_q;
    last_d     = last_q;
    pos_d      = pos_q;
    rd_vld_d   = 1'b0;
    rd_w_d     = scan_w;
    rd_idx_d   = rd_idx_q;
    rd_rng_d   = rd_rng_q;
    emit_d     = emit_q;
    acc_clr    = 1'b0;
    out_load   = 1'b0;
    out_word_d = out_word_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    out_oor_d  = out_oor_q;
    case (state_q)
      ST_IDLE: begin
        if (head_vld_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            OP_WRITE: mem_we = head_i.in_range;
            OP_READ: begin
              mem_re   = 1'b1;
              rd_idx_d = head_i.addr[WordIdxW-1:0];
              rd_rng_d = head_i.in_range;
              state_d  = ST_RD_OUT;
            end
            OP_QUERY: begin
              sel_d   = head_i.sel;
              last_d  = head_i.last;
              scan_d  = '0;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_RD_OUT: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_word_d = rd_rng_q ? mem_rdata_q : '0;
          out_idx_d  = IdxOutW'(rd_idx_q);
          out_last_d = 1'b1;
          out_oor_d  = ~rd_rng_q;
          state_d    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        mem_addr = {blk[BlkIdxW-1:0], scan_w};
        mem_re   = hit;
        rd_vld_d = hit;
        scan_d   = scan_q + 1'b1;
        if (scan_q == {ScanW{1'b1}}) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read lands in the accumulator on this edge
        if (last_q) begin
          pos_d   = '0;
          emit_d  = '0;
          state_d = ST_EMIT;
        end else begin
          if (pos_q < PosW'(PosLimit)) begin
            pos_d = pos_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_load   = 1'b1;
          acc_clr    = 1'b1;
          out_word_d = acc_q[emit_q];
          out_idx_d  = IdxOutW'(emit_q);
          out_last_d = (emit_q == WordIdxW'(WordsPerBlock - 1));
          out_oor_d  = 1'b0;
          emit_d     = emit_q + 1'b1;
          if (emit_q == WordIdxW'(WordsPerBlock - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      last_q    <= 1'b0;
      pos_q     <= '0;
      rd_vld_q  <= 1'b0;
      emit_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      last_q   <= last_d;
      pos_q    <= pos_d;
      rd_vld_q <= rd_vld_d;
      emit_q   <= emit_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    rd_w_q   <= rd_w_d;
    rd_idx_q <= rd_idx_d;
    rd_rng_q <= rd_rng_d;
    if (out_load) begin
      out_word_q <= out_word_d;
      out_idx_q  <= out_idx_d;
      out_last_q <= out_last_d;
      out_oor_q  <= out_oor_d;
    end
  end

  // Store: one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= head_i.wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  // Accumulator: XOR in one store word a cycle, cleared word by word on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WordsPerBlock; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      if (rd_vld_q) begin
        acc_q[rd_w_q] <= acc_q[rd_w_q] ^ mem_rdata_q;
      end
      if (acc_clr) begin
        acc_q[emit_q] <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW - OutFieldW){1'b0}}, out_idx_q, out_word_q};
  assign m_axis_tuser_o  = out_oor_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire
